[src/u2da_pkg.sv]
`timescale 1ns / 1ps
// Package for the unsigned-to-decimal ASCII converter.
// Holds shared constants, the controller state type and the ctrl/datapath structs.
// No dependencies.
package u2da_pkg;

    // Default input width and the fixed decimal working width
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DEC_W               = 34;
    localparam int MAX_DIGITS          = 10;
    localparam int CNT_W               = 4;
    localparam int CHAR_W              = 6;
    localparam int M_TDATA_W           = 16;

    localparam logic [DEC_W-1:0]  DEC_MAX    = 34'd9999999999;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Powers of ten, one per digit position
    localparam logic [DEC_W-1:0] POW10 [MAX_DIGITS] = '{
        34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
        34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
    };

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_digit;
    } sts_t;

endpackage

[src/u2da_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the unsigned-to-decimal ASCII converter.
// Depends on u2da_pkg for the state type and the command/status structs.
module u2da_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  u2da_pkg::sts_t  sts,
    output u2da_pkg::cmd_t  cmd
);

    u2da_pkg::state_t state_reg;
    u2da_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u2da_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: idle until a transfer, emit until the units digit leaves
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            u2da_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = u2da_pkg::ST_EMIT;
            end
            u2da_pkg::ST_EMIT: begin
                if (sts.out_free && sts.last_digit) state_next = u2da_pkg::ST_IDLE;
            end
            default: state_next = u2da_pkg::ST_IDLE;
        endcase
    end

    // Outputs: load on input transfer, step whenever the output register frees up
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            u2da_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            u2da_pkg::ST_EMIT: begin
                cmd.step = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[src/u2da_dp.sv]
`timescale 1ns / 1ps
// Datapath for the unsigned-to-decimal ASCII converter: remainder, digit
// position, digit extraction against a power-of-ten table, output register.
// Depends on u2da_pkg.
module u2da_dp #(
    parameter int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEFAULT,
    parameter int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [S_TDATA_W-1:0]               s_tdata,
    input  u2da_pkg::cmd_t                     cmd,
    output u2da_pkg::sts_t                     sts,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [u2da_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int DEC_W  = u2da_pkg::DEC_W;
    localparam int NDIG   = u2da_pkg::MAX_DIGITS;
    localparam int CNT_W  = u2da_pkg::CNT_W;
    localparam int CHAR_W = u2da_pkg::CHAR_W;
    localparam int EXT_W  = (VALUE_WIDTH > DEC_W) ? VALUE_WIDTH : DEC_W;

    logic [DEC_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              olast_reg, olast_next;

    logic [EXT_W-1:0]  value_ext;
    logic              value_sat;
    logic [DEC_W-1:0]  value_dec;
    logic [NDIG-1:1]   len_ge;
    logic [CNT_W-1:0]  value_len;
    logic [DEC_W-1:0]  mult_tab [NDIG][10];
    logic [9:1]        dig_ge;
    logic [CNT_W-1:0]  digit;

    // Constant table of d * 10^p for every position and digit
    for (genvar gp = 0; gp < NDIG; gp++) begin : g_pos
        for (genvar gd = 0; gd < 10; gd++) begin : g_dig
            localparam logic [63:0] MULT = 64'(u2da_pkg::POW10[gp]) * 64'(gd);
            assign mult_tab[gp][gd] = MULT[DEC_W-1:0];
        end
    end

    // Mask to the value width and saturate to ten digits
    always_comb begin
        value_ext = EXT_W'(s_tdata[VALUE_WIDTH-1:0]);
        value_sat = value_ext > EXT_W'(u2da_pkg::DEC_MAX);
        value_dec = value_sat ? u2da_pkg::DEC_MAX : value_ext[DEC_W-1:0];
    end

    // Count digits: one plus the number of powers of ten not above the value
    always_comb begin
        for (int p = 1; p < NDIG; p++) begin
            len_ge[p] = value_dec >= u2da_pkg::POW10[p];
        end
        value_len = CNT_W'($countones(len_ge)) + CNT_W'(1);
    end

    // Extract the digit at the current position by parallel compare
    always_comb begin
        for (int d = 1; d < 10; d++) begin
            dig_ge[d] = rem_reg >= mult_tab[pos_reg][d];
        end
        digit = CNT_W'($countones(dig_ge));
    end

    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.last_digit = (pos_reg == '0);

    // Next values: load a new value, step one digit, drain the output register
    always_comb begin
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        ocnt_next    = ocnt_reg;
        olast_next   = olast_reg;
        if (m_tready) m_valid_next = 1'b0;
        if (cmd.load) begin
            rem_next = value_dec;
            pos_next = value_len - CNT_W'(1);
            cnt_next = CNT_W'(1);
        end
        if (cmd.step) begin
            rem_next     = rem_reg - mult_tab[pos_reg][digit];
            pos_next     = pos_reg - CNT_W'(1);
            cnt_next     = cnt_reg + CNT_W'(1);
            m_valid_next = 1'b1;
            char_next    = u2da_pkg::ASCII_ZERO + CHAR_W'(digit);
            ocnt_next    = cnt_reg;
            olast_next   = (pos_reg == '0);
        end
    end

    // Control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        char_reg  <= char_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = u2da_pkg::M_TDATA_W'({ocnt_reg, char_reg});

endmodule

[src/unsigned_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// Unsigned binary to decimal ASCII converter, top level.
// Depends on u2da_pkg, u2da_ctrl and u2da_dp.
//
// Usage:
//   The slave channel takes one unsigned value per transfer in s_tdata.
//   The master channel returns its decimal digits as ASCII characters, most
//   significant first, no leading zeros; zero gives a single '0'. m_tlast
//   marks the units digit, and each transfer carries its position in the run.
//   Values above 9999999999 (only possible for widths above 33) saturate to it.
//   An input transfer first loads the remainder and digit position registers;
//   then the shared compare-and-subtract unit, against a power-of-ten table,
//   writes one digit per cycle into the output register while the receiver
//   does not stall. s_tready is high only between values; the next value is
//   taken while the final character still waits in the output register.
//   When the receiver stalls, the output register holds its character and
//   digit extraction pauses.
//   Reset clears the controller and the output valid; no value is in flight.
module unsigned_to_decimal_ascii #(
    parameter int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEFAULT,
    parameter int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [S_TDATA_W-1:0]           s_tdata,   // [VALUE_WIDTH-1:0] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [u2da_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [9:6] char_count
    output logic                           m_tlast
);

    u2da_pkg::cmd_t cmd;
    u2da_pkg::sts_t sts;

    u2da_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    u2da_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .S_TDATA_W   (S_TDATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[src/u2da_checker.sv]
`timescale 1ns / 1ps
// Port checker for the unsigned-to-decimal ASCII converter, bound to the top.
// Depends on u2da_pkg for the output data width.
module u2da_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [u2da_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // Every character is a decimal digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] >= 6'd48 && m_tdata[5:0] <= 6'd57))
        else $error("character outside '0'..'9'");

    // Position stays within one to ten
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:6] != 4'd0 && m_tdata[9:6] <= 4'd10))
        else $error("character position out of range");

    // A run of more than one character never opens with a zero
    a_no_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9:6] == 4'd1 && !m_tlast) |-> m_tdata[5:0] != 6'd48)
        else $error("leading zero emitted");

    // Hold a stalled transfer
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled transfer changed");

    // Nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind unsigned_to_decimal_ascii u2da_checker u_u2da_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[bench/u2da_digit_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the decimal ASCII converter: watches both stream channels,
// predicts the digit characters of every accepted value and compares them.
// Depends on u2da_pkg for the result field widths.
module u2da_digit_checker #(
    parameter int VALUE_WIDTH = 32,
    parameter int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [S_TDATA_W-1:0]           s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [u2da_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             mismatches,
    output int                             chars_pending
);

    localparam int                      CHAR_W      = u2da_pkg::CHAR_W;
    localparam int                      CNT_W       = u2da_pkg::CNT_W;
    localparam int                      DIGIT_LIMIT = 10;
    localparam logic [63:0]             DEC_CEILING = 64'd9999999999;
    localparam logic [CHAR_W-1:0]       CHAR_ZERO   = 6'd48;

    // One character transfer as it leaves the block
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic [CNT_W-1:0]  char_count;
    } digit_xfer_t;

    digit_xfer_t expected_chars[$];

    // Split a value into decimal digits and queue its characters, most significant first
    task automatic queue_decimal_digits(input logic [S_TDATA_W-1:0] raw);
        logic [63:0]       val;
        logic [3:0]        digs [DIGIT_LIMIT];
        int                n;
        digit_xfer_t       x;
        val = 64'(raw);
        if (VALUE_WIDTH < 64) begin
            val &= (64'd1 << VALUE_WIDTH) - 64'd1;
        end
        // clamp to ten digits for wide configurations
        if (val > DEC_CEILING) begin
            val = DEC_CEILING;
        end
        n = 0;
        do begin
            digs[n] = 4'(val % 64'd10);
            val     = val / 64'd10;
            n++;
        end while (val != 0 && n < DIGIT_LIMIT);
        for (int k = n - 1; k >= 0; k--) begin
            x.digit_char = CHAR_ZERO + CHAR_W'(digs[k]);
            x.last       = (k == 0);
            x.char_count = CNT_W'(n - k);
            expected_chars.push_back(x);
        end
    endtask

    // Check each character transfer against the oldest prediction, then log new values
    always @(posedge aclk) begin : watch
        digit_xfer_t got;
        digit_xfer_t want;
        if (!aresetn) begin
            expected_chars.delete();
            mismatches    = 0;
            chars_pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.digit_char = m_tdata[5:0];
                got.last       = m_tlast;
                got.char_count = m_tdata[9:6];
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character %0d last %0b count %0d",
                             $time, got.digit_char, got.last, got.char_count);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %0d last %0b count %0d, got %0d %0b %0d",
                                 $time, want.digit_char, want.last, want.char_count,
                                 got.digit_char, got.last, got.char_count);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                queue_decimal_digits(s_tdata);
            end
            chars_pending = expected_chars.size();
        end
    end

endmodule

[bench/unsigned_to_decimal_ascii_test.sv]
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, value stimulus and verdict.
// Depends on unsigned_to_decimal_ascii, u2da_digit_checker and u2da_pkg.
module unsigned_to_decimal_ascii_test;

    localparam int VALUE_WIDTH   = 32;
    localparam int S_TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_VALUES = 320;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 200000;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [S_TDATA_W-1:0]           s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [u2da_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    int                             mismatches;
    int                             chars_pending;
    int                             cycles = 0;
    bit                             steady = 1'b0;  // no idling on either side

    // Digit-count boundaries, zero and the top of the range
    logic [31:0] corner_values [25] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
        32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
        32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
        32'd999999999, 32'd1000000000, 32'd4294967295, 32'd2147483648,
        32'd4294967294, 32'd4000000000, 32'd1234567890
    };

    unsigned_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    u2da_digit_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .chars_pending(chars_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: accept most cycles, stall at random
    always @(negedge aclk) begin
        m_tready <= aresetn && (steady || $urandom_range(99) >= 8);
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("unsigned_to_decimal_ascii_test: FAIL");
            $finish;
        end
    end

    // Offer one value and hold it until the transfer completes; call at a falling edge
    task automatic send_value(input logic [S_TDATA_W-1:0] v);
        while (!steady && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Spread values over all digit counts, with many near powers of ten
    function automatic logic [31:0] random_value();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);
            2: begin
                repeat ($urandom_range(9)) p = p * 32'd10;
                return p + 32'($urandom_range(2)) - 32'd1;
            end
            default: return 32'($urandom_range(999));
        endcase
    endfunction

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed values
        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end

        // Random values, with a quiet stretch and one full drain
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            steady = (i >= 100 && i < 180);
            if (i == 220) begin
                s_tvalid <= 1'b0;
                wait (chars_pending == 0);
                @(negedge aclk);
            end
            send_value(random_value());
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // Drain and give the verdict
        wait (chars_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && chars_pending == 0) begin
            $display("unsigned_to_decimal_ascii_test: PASS");
        end else begin
            $display("unsigned_to_decimal_ascii_test: FAIL");
        end
        $finish;
    end

endmodule

[unsigned_to_decimal_ascii.f]
src/u2da_pkg.sv
src/u2da_ctrl.sv
src/u2da_dp.sv
src/unsigned_to_decimal_ascii.sv
src/u2da_checker.sv
bench/u2da_digit_checker.sv
bench/unsigned_to_decimal_ascii_test.sv
